>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/mrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed-radix digit register package
// Widths, codes and the structs shared by controller, datapath and config port.
// ----------------------------------------------------------------------------
package mrd_pkg;

	localparam int VAL_W      = 48;
	localparam int WT_W       = VAL_W + 1;
	localparam int BASE_W     = 8;
	localparam int NUM_BASE   = 6;
	localparam int NUM_REGS   = 7;
	localparam int ADDR_W     = 5;
	localparam int FIFO_DEPTH = 8;

	localparam int DEF_MAX_DIGITS = 6;
	localparam int DEF_DIGIT_BITS = 8;

	localparam logic [WT_W-1:0] WCAP = WT_W'(1) << VAL_W;

	// register indexes
	localparam logic [2:0] REG_DIGITS = 3'd6;
	localparam logic [2:0] REG_END    = 3'd7;

	// command codes
	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_SET  = 3'd1;
	localparam logic [2:0] CMD_ADD  = 3'd2;
	localparam logic [2:0] CMD_READ = 3'd3;
	localparam logic [2:0] CMD_INC  = 3'd4;
	localparam logic [2:0] CMD_DEC  = 3'd5;
	localparam logic [2:0] CMD_CMP  = 3'd6;

	// status codes
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_BADPOS = 2'd1;
	localparam logic [1:0] STS_RANGE  = 2'd2;
	localparam logic [1:0] STS_WRAP   = 2'd3;

	typedef enum logic [1:0] {
		DSEL_END = 2'd0,
		DSEL_W   = 2'd1,
		DSEL_R   = 2'd2
	} dsel_t;

	typedef struct packed {
		logic [2:0]        idx;
		logic [BASE_W-1:0] val;
	} cfg_word_t;

	typedef struct packed {
		logic  accept;
		logic  cfg_apply;
		logic  w_init;
		logic  w_step;
		logic  div_load;
		dsel_t div_sel;
		logic  div_step;
		logic  exec;
		logic  mul;
		logic  add;
		logic  result;
	} mrd_cmd_t;

	typedef struct packed {
		logic pos_ok;
		logic modify;
		logic div_last;
		logic w_last;
		logic red_need;
	} mrd_stat_t;

endpackage

>>> sv/mrd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration port
// APB register file with a queue of written words for the datapath to apply.
// ----------------------------------------------------------------------------
module mrd_cfg import mrd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              cfg_pop,
	output logic              cfg_ne,
	output cfg_word_t         cfg_head
);

	localparam int PW = $clog2(FIFO_DEPTH);

	logic [BASE_W-1:0] base_q [NUM_BASE];
	logic [2:0]        diu_q;
	cfg_word_t         fifo_q [FIFO_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;
	logic [2:0]        ridx;
	logic              wr_en;
	logic              push;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign push   = wr_en && (ridx != REG_END) && (cnt_q < (PW+1)'(FIFO_DEPTH));
	assign cfg_ne = (cnt_q != '0);
	assign cfg_head = fifo_q[rd_q];

	always_comb begin
		prdata = '0;
		if (ridx == REG_DIGITS) begin
			prdata = {29'd0, diu_q};
		end else if (ridx != REG_END) begin
			prdata = {24'd0, base_q[ridx]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BASE; i++) base_q[i] <= BASE_W'(2);
			diu_q <= 3'd6;
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && ridx == REG_DIGITS) begin
				diu_q <= pwdata[2:0];
			end else if (wr_en && ridx != REG_END) begin
				base_q[ridx] <= pwdata[BASE_W-1:0];
			end
			if (push) wr_q <= wr_q + 1'b1;
			if (cfg_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(cfg_pop);
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{idx: ridx, val: pwdata[BASE_W-1:0]};
		end
	end

endmodule

>>> sv/mrd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed-radix datapath
// Held value, place weights, bit-serial divider and digit update arithmetic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mrd_dp import mrd_pkg::*; #(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS,
	parameter int DIGIT_BITS = DEF_DIGIT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mrd_cmd_t          dcmd,
	output mrd_stat_t         dstat,
	input  cfg_word_t         cfg_head,
	input  logic [2:0]        cmd,
	input  logic [2:0]        digit_position,
	input  logic signed [8:0] digit_amount,
	input  logic [VAL_W-1:0]  whole_value,
	output logic [VAL_W-1:0]  current_value,
	output logic [7:0]        selected_digit,
	output logic              is_less,
	output logic              is_equal,
	output logic              is_greater,
	output logic [1:0]        status
);

	localparam int WIX = $clog2(MAX_DIGITS + 1);
	localparam logic [BASE_W-1:0] RMASK = (DIGIT_BITS >= BASE_W) ? {BASE_W{1'b1}}
		: BASE_W'((1 << DIGIT_BITS) - 1);
	localparam logic [3:0]     MAXD     = 4'(MAX_DIGITS);
	localparam logic [WIX-1:0] KLAST    = WIX'(MAX_DIGITS - 1);
	localparam logic [5:0]     DIV_LAST = 6'(VAL_W - 1);

	// configuration in force
	logic [BASE_W-1:0] base_q [NUM_BASE];
	logic [2:0]        diu_q;
	logic [WT_W-1:0]   weights_q [MAX_DIGITS+1];
	logic [WT_W-1:0]   acc_q;
	logic [WIX-1:0]    k_q;
	logic [WT_W-1:0]   end_q;

	// item and result
	logic [VAL_W-1:0]  held_q;
	logic [2:0]        cmd_q;
	logic [2:0]        pos_q;
	logic signed [8:0] amt_q;
	logic [VAL_W-1:0]  whole_q;
	logic [1:0]        status_q;
	logic              lt_q, eq_q, gt_q;
	logic [7:0]        digit_q;
	logic              modify_q;
	logic [BASE_W-1:0] radix_q;
	logic [WT_W-1:0]   w_q;
	logic [VAL_W-1:0]  prod_q;
	logic              neg_q;

	// divider
	logic [WT_W-1:0]   rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic [WT_W-1:0]   dsr_q;
	logic [5:0]        dcnt_q;
	dsel_t             dsel_q;

	logic [3:0]        n4;
	logic              pos_ok;
	logic [WIX-1:0]    pidx;
	logic [3:0]        ridx;
	logic [BASE_W-1:0] rb;
	logic [BASE_W-1:0] radix;
	logic [WT_W+BASE_W-1:0] wprod;
	logic [WT_W-1:0]   wsat;
	logic [VAL_W-1:0]  held_nx;
	logic [1:0]        status_nx;
	logic              modify_nx;
	logic [WT_W:0]     shifted;
	logic              ge;
	logic [WT_W-1:0]   rem_n;
	logic [VAL_W-1:0]  quo_n;
	logic signed [10:0] dsum;
	logic [7:0]        rmax;
	logic [7:0]        nd;
	logic signed [9:0] diff;
	logic [9:0]        magx;
	logic [WT_W+7:0]   mprod;

	always_comb begin
		n4 = (diu_q == 3'd0) ? 4'd1 : {1'b0, diu_q};
		if (n4 > MAXD) n4 = MAXD;
	end

	assign pos_ok = ({1'b0, pos_q} < n4);
	assign pidx   = WIX'(pos_q);
	assign ridx   = dcmd.w_step ? 4'(k_q) : {1'b0, pos_q};

	always_comb begin
		rb = 8'd1;
		if (ridx < 4'(NUM_BASE)) rb = base_q[ridx[2:0]] & RMASK;
		radix = (rb == '0) ? BASE_W'(1) : rb;
	end

	// weight rebuild: saturate at the cap
	assign wprod = acc_q * radix;
	assign wsat  = (wprod > (WT_W+BASE_W)'(WCAP)) ? WCAP : wprod[WT_W-1:0];

	// command effect on the held value
	always_comb begin
		held_nx   = held_q;
		status_nx = STS_OK;
		modify_nx = 1'b0;
		unique case (cmd_q)
			CMD_LOAD: begin
				if ({1'b0, whole_q} >= end_q) status_nx = STS_RANGE;
				else held_nx = whole_q;
			end
			CMD_SET: begin
				if (!pos_ok) status_nx = STS_BADPOS;
				else if (amt_q[8] || amt_q[7:0] >= radix) status_nx = STS_RANGE;
				else modify_nx = 1'b1;
			end
			CMD_ADD: begin
				if (!pos_ok) status_nx = STS_BADPOS;
				else modify_nx = 1'b1;
			end
			CMD_READ: begin
				if (!pos_ok) status_nx = STS_BADPOS;
			end
			CMD_INC: begin
				if ({1'b0, held_q} + WT_W'(1) >= end_q) begin
					held_nx   = '0;
					status_nx = STS_WRAP;
				end else begin
					held_nx = held_q + 1'b1;
				end
			end
			CMD_DEC: begin
				if (held_q == '0) begin
					held_nx   = VAL_W'(end_q - WT_W'(1));
					status_nx = STS_WRAP;
				end else begin
					held_nx = held_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// one restoring step
	assign shifted = {rem_q, quo_q[VAL_W-1]};
	assign ge      = (shifted >= {1'b0, dsr_q});
	assign rem_n   = ge ? WT_W'(shifted - {1'b0, dsr_q}) : shifted[WT_W-1:0];
	assign quo_n   = {quo_q[VAL_W-2:0], ge};

	// new digit and the weighted change
	always_comb begin
		rmax = radix_q - 1'b1;
		dsum = $signed({3'b000, digit_q}) + $signed({{2{amt_q[8]}}, amt_q});
		if (cmd_q == CMD_SET) nd = amt_q[7:0];
		else if (dsum < 0) nd = 8'd0;
		else if (dsum > $signed({3'b000, rmax})) nd = rmax;
		else nd = dsum[7:0];
		diff  = $signed({2'b00, nd}) - $signed({2'b00, digit_q});
		magx  = (diff < 0) ? 10'(-diff) : 10'(diff);
		mprod = magx[7:0] * w_q;
	end

	assign dstat.pos_ok   = pos_ok;
	assign dstat.modify   = modify_q;
	assign dstat.div_last = (dcnt_q == DIV_LAST);
	assign dstat.w_last   = (k_q == KLAST);
	assign dstat.red_need = ({1'b0, held_q} >= end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BASE; i++) base_q[i] <= BASE_W'(2);
			diu_q    <= 3'd6;
			held_q   <= '0;
			modify_q <= 1'b0;
			dcnt_q   <= '0;
			dsel_q   <= DSEL_END;
		end else begin
			if (dcmd.cfg_apply) begin
				if (cfg_head.idx == REG_DIGITS) diu_q <= cfg_head.val[2:0];
				else if (cfg_head.idx != REG_END) base_q[cfg_head.idx] <= cfg_head.val;
			end
			if (dcmd.exec) begin
				held_q   <= held_nx;
				modify_q <= modify_nx;
			end
			if (dcmd.add) held_q <= neg_q ? held_q - prod_q : held_q + prod_q;
			if (dcmd.div_load) begin
				dcnt_q <= '0;
				dsel_q <= dcmd.div_sel;
			end else if (dcmd.div_step) begin
				if (dcnt_q == DIV_LAST) begin
					dcnt_q <= '0;
					if (dsel_q == DSEL_END) held_q <= rem_n[VAL_W-1:0];
					// quotient by weight feeds the modulo by the radix
					if (dsel_q == DSEL_W) dsel_q <= DSEL_R;
				end else begin
					dcnt_q <= dcnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.accept) begin
			cmd_q   <= cmd;
			pos_q   <= digit_position;
			amt_q   <= digit_amount;
			whole_q <= whole_value;
		end
		if (dcmd.w_init) begin
			weights_q[0] <= WT_W'(1);
			acc_q        <= WT_W'(1);
			k_q          <= '0;
		end
		if (dcmd.w_step) begin
			weights_q[WIX'(k_q + 1'b1)] <= wsat;
			acc_q <= wsat;
			k_q   <= k_q + 1'b1;
			if (4'(k_q) + 4'd1 == n4) end_q <= wsat;
		end
		if (dcmd.exec) begin
			status_q <= status_nx;
			lt_q     <= (cmd_q == CMD_CMP) && (held_q < whole_q);
			eq_q     <= (cmd_q == CMD_CMP) && (held_q == whole_q);
			gt_q     <= (cmd_q == CMD_CMP) && (held_q > whole_q);
			digit_q  <= 8'd0;
			radix_q  <= radix;
			w_q      <= weights_q[pidx];
		end
		if (dcmd.div_load) begin
			rem_q <= '0;
			if (dcmd.div_sel == DSEL_END) begin
				quo_q <= held_q;
				dsr_q <= end_q;
			end else begin
				quo_q <= held_nx;
				dsr_q <= weights_q[pidx];
			end
		end else if (dcmd.div_step) begin
			if (dcnt_q == DIV_LAST && dsel_q == DSEL_W) begin
				rem_q <= '0;
				quo_q <= quo_n;
				dsr_q <= WT_W'(radix_q);
			end else begin
				rem_q <= rem_n;
				quo_q <= quo_n;
			end
			if (dcnt_q == DIV_LAST && dsel_q == DSEL_R) digit_q <= rem_n[7:0];
		end
		if (dcmd.mul) begin
			digit_q <= nd;
			prod_q  <= mprod[VAL_W-1:0];
			neg_q   <= (diff < 0);
		end
	end

	assign current_value  = held_q;
	assign selected_digit = digit_q;
	assign is_less        = lt_q;
	assign is_equal       = eq_q;
	assign is_greater     = gt_q;
	assign status         = status_q;

	`ASSERT_IMPLIES(a_held_below_end, clk, arst_n, dcmd.result, {1'b0, held_q} < end_q, "held value not below end")
	`ASSERT_IMPLIES(a_digit_below_radix, clk, arst_n, dcmd.result && pos_ok, digit_q < radix_q, "digit not below radix")
	`ASSERT_IMPLIES(a_one_flag, clk, arst_n, dcmd.result, $countones({lt_q, eq_q, gt_q}) <= 1, "compare flags clash")

endmodule

>>> sv/mrd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed-radix controller
// Sequences configuration apply, weight rebuild, reduction and commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mrd_ctrl import mrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	input  logic      cfg_ne,
	input  mrd_stat_t dstat,
	output mrd_cmd_t  dcmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_CPOP  = 12'b000000000010,
		S_WINIT = 12'b000000000100,
		S_WSTEP = 12'b000000001000,
		S_RCHK  = 12'b000000010000,
		S_RDIV  = 12'b000000100000,
		S_EXEC  = 12'b000001000000,
		S_QDIV  = 12'b000010000000,
		S_DDIV  = 12'b000100000000,
		S_MUL   = 12'b001000000000,
		S_ADD   = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE) || cfg_ne;
	assign done = (state_q == S_DONE);

	always_comb begin
		state_d = state_q;
		dcmd    = '0;
		dcmd.div_sel = DSEL_END;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_ne) begin
					state_d = S_CPOP;
				end else if (start) begin
					dcmd.accept = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_CPOP: begin
				dcmd.cfg_apply = 1'b1;
				state_d        = S_WINIT;
			end
			S_WINIT: begin
				dcmd.w_init = 1'b1;
				state_d     = S_WSTEP;
			end
			S_WSTEP: begin
				dcmd.w_step = 1'b1;
				if (dstat.w_last) state_d = S_RCHK;
			end
			S_RCHK: begin
				if (dstat.red_need) begin
					dcmd.div_load = 1'b1;
					state_d       = S_RDIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RDIV: begin
				dcmd.div_step = 1'b1;
				if (dstat.div_last) state_d = S_IDLE;
			end
			S_EXEC: begin
				dcmd.exec = 1'b1;
				if (dstat.pos_ok) begin
					dcmd.div_load = 1'b1;
					dcmd.div_sel  = DSEL_W;
					state_d       = S_QDIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_QDIV: begin
				dcmd.div_step = 1'b1;
				if (dstat.div_last) state_d = S_DDIV;
			end
			S_DDIV: begin
				dcmd.div_step = 1'b1;
				if (dstat.div_last) state_d = dstat.modify ? S_MUL : S_DONE;
			end
			S_MUL: begin
				dcmd.mul = 1'b1;
				state_d  = S_ADD;
			end
			S_ADD: begin
				dcmd.add = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				dcmd.result = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// rebuild weights straight out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WINIT;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEXT(a_done_single, clk, arst_n, state_q == S_DONE, state_q == S_IDLE, "result strobe held")

endmodule

>>> sv/mixed_radix_digit_register.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed-radix digit register
// Holds one number in mixed radix and runs load, digit and counting commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with cmd, digit_position, digit_amount and
//   whole_value; the word is taken at an edge where busy is low.
//   Result channel: done is high for exactly one cycle with current_value,
//   selected_digit, the compare flags and status. The receiver cannot stall.
//   A command with a bad position goes straight to done. Every other command
//   runs the one-bit-per-cycle divider: 48 steps for the quotient by the place
//   weight, 48 more for the remainder by the radix; set and add that change
//   the digit then multiply and add the change. Busy drops in the cycle after
//   done unless a configuration word is queued.
//   Configuration: APB writes, except to the end index, land in an 8-word
//   queue. Each queued word is applied and the weights are rebuilt; the held
//   value is then reduced modulo the new end when it is not below it. Busy stays high meanwhile.
//   Reset: radices 2, six digits, held value zero; busy is high after reset
//   while the weights are built.
// ----------------------------------------------------------------------------
module mixed_radix_digit_register import mrd_pkg::*; #(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS,
	parameter int DIGIT_BITS = DEF_DIGIT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        cmd,
	input  logic [2:0]        digit_position,
	input  logic signed [8:0] digit_amount,
	input  logic [VAL_W-1:0]  whole_value,
	output logic              done,
	output logic [VAL_W-1:0]  current_value,
	output logic [7:0]        selected_digit,
	output logic              is_less,
	output logic              is_equal,
	output logic              is_greater,
	output logic [1:0]        status
);

	mrd_cmd_t  dcmd;
	mrd_stat_t dstat;
	cfg_word_t cfg_head;
	logic      cfg_ne;

	mrd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg_pop  (dcmd.cfg_apply),
		.cfg_ne   (cfg_ne),
		.cfg_head (cfg_head)
	);

	mrd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cfg_ne (cfg_ne),
		.dstat  (dstat),
		.dcmd   (dcmd)
	);

	mrd_dp #(
		.MAX_DIGITS (MAX_DIGITS),
		.DIGIT_BITS (DIGIT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dcmd           (dcmd),
		.dstat          (dstat),
		.cfg_head       (cfg_head),
		.cmd            (cmd),
		.digit_position (digit_position),
		.digit_amount   (digit_amount),
		.whole_value    (whole_value),
		.current_value  (current_value),
		.selected_digit (selected_digit),
		.is_less        (is_less),
		.is_equal       (is_equal),
		.is_greater     (is_greater),
		.status         (status)
	);

endmodule
